### src/gshca_pkg.sv
package gshca_pkg;

	// Sample width of the sensor converter.
	localparam int unsigned SAMPLE_BITS = 12;

	localparam int unsigned PHASE_W     = 18;
	localparam int unsigned LEVEL_W     = 8;
	localparam int unsigned THRESH_W    = 12;
	localparam int unsigned HOLD_W      = 16;
	localparam int unsigned REPORT_W    = 22;
	localparam int unsigned CFG_DATA_W  = 22;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned ALARM_W     = 2;

	// Width used to compare the sample against the threshold.
	localparam int unsigned CMP_W = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_PHASE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_PHASE  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_LEVEL   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LEVEL  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_HOLD        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_REPORT_INTV = 3'd6;

	// Reset values of the configuration registers.
	localparam logic [PHASE_W-1:0]  RST_LOW_PHASE   = 18'd90000;
	localparam logic [PHASE_W-1:0]  RST_HIGH_PHASE  = 18'd60000;
	localparam logic [LEVEL_W-1:0]  RST_LOW_LEVEL   = 8'd127;
	localparam logic [LEVEL_W-1:0]  RST_HIGH_LEVEL  = 8'd255;
	localparam logic [THRESH_W-1:0] RST_THRESHOLD   = 12'd800;
	localparam logic [HOLD_W-1:0]   RST_HOLD        = 16'd10000;
	localparam logic [REPORT_W-1:0] RST_REPORT_INTV = 22'd1000;

	// Alarm state codes.
	localparam logic [ALARM_W-1:0] ALM_CLEAR     = 2'd0;
	localparam logic [ALARM_W-1:0] ALM_POT_ALARM = 2'd1;
	localparam logic [ALARM_W-1:0] ALM_ALARM     = 2'd2;
	localparam logic [ALARM_W-1:0] ALM_POT_RECOV = 2'd3;

	typedef struct packed {
		logic [PHASE_W-1:0]  low_phase_ms;
		logic [PHASE_W-1:0]  high_phase_ms;
		logic [LEVEL_W-1:0]  low_drive_level;
		logic [LEVEL_W-1:0]  high_drive_level;
		logic [THRESH_W-1:0] alarm_threshold;
		logic [HOLD_W-1:0]   hold_ms;
		logic [REPORT_W-1:0] report_interval_ms;
	} cfg_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic                   status_request;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] heater_drive;
		logic               heater_high;
		logic [ALARM_W-1:0] alarm_state;
		logic               level_high;
		logic               report;
	} out_item_t;

	// Current and next alarm code, as seen by the top level.
	typedef struct packed {
		logic [ALARM_W-1:0] code_cur;
		logic [ALARM_W-1:0] code_nxt;
	} alarm_stat_t;

endpackage

### src/gshca_cfg.sv
module gshca_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gshca_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gshca_pkg::CFG_DATA_W-1:0]     cfg_data,
	output gshca_pkg::cfg_t                      cfg
);
	import gshca_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_phase_ms       <= RST_LOW_PHASE;
			cfg_q.high_phase_ms      <= RST_HIGH_PHASE;
			cfg_q.low_drive_level    <= RST_LOW_LEVEL;
			cfg_q.high_drive_level   <= RST_HIGH_LEVEL;
			cfg_q.alarm_threshold    <= RST_THRESHOLD;
			cfg_q.hold_ms            <= RST_HOLD;
			cfg_q.report_interval_ms <= RST_REPORT_INTV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW_PHASE:   cfg_q.low_phase_ms       <= cfg_data[PHASE_W-1:0];
				REG_HIGH_PHASE:  cfg_q.high_phase_ms      <= cfg_data[PHASE_W-1:0];
				REG_LOW_LEVEL:   cfg_q.low_drive_level    <= cfg_data[LEVEL_W-1:0];
				REG_HIGH_LEVEL:  cfg_q.high_drive_level   <= cfg_data[LEVEL_W-1:0];
				REG_THRESHOLD:   cfg_q.alarm_threshold    <= cfg_data[THRESH_W-1:0];
				REG_HOLD:        cfg_q.hold_ms            <= cfg_data[HOLD_W-1:0];
				REG_REPORT_INTV: cfg_q.report_interval_ms <= cfg_data[REPORT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/gshca_phase.sv
module gshca_phase (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  gshca_pkg::cfg_t cfg,
	output logic            phase_high_nxt
);
	import gshca_pkg::*;

	logic               phase_high_q;
	logic [PHASE_W-1:0] phase_elapsed_q;
	logic [PHASE_W-1:0] limit;
	logic               due;
	logic [PHASE_W-1:0] elapsed_nxt;

	always_comb begin
		limit          = phase_high_q ? cfg.high_phase_ms : cfg.low_phase_ms;
		due            = (phase_elapsed_q >= limit);
		phase_high_nxt = due ? ~phase_high_q : phase_high_q;
		elapsed_nxt    = due ? '0 : phase_elapsed_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_high_q    <= 1'b0;
			phase_elapsed_q <= '0;
		end else if (step) begin
			phase_high_q    <= phase_high_nxt;
			phase_elapsed_q <= elapsed_nxt;
		end
	end

endmodule

### src/gshca_alarm.sv
module gshca_alarm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  gshca_pkg::cfg_t                   cfg,
	input  logic [gshca_pkg::SAMPLE_BITS-1:0] sample,
	output gshca_pkg::alarm_stat_t            stat
);
	import gshca_pkg::*;

	logic [ALARM_W-1:0] code_q;
	logic [HOLD_W-1:0]  elapsed_q;
	logic [ALARM_W-1:0] code_nxt;
	logic [HOLD_W-1:0]  elapsed_nxt;
	logic [CMP_W-1:0]   sample_x;
	logic [CMP_W-1:0]   thresh_x;
	logic               above;
	logic               below;
	logic               due;

	always_comb begin
		sample_x    = CMP_W'(sample);
		thresh_x    = CMP_W'(cfg.alarm_threshold);
		above       = (sample_x > thresh_x);
		below       = (sample_x < thresh_x);
		due         = (elapsed_q >= cfg.hold_ms);
		code_nxt    = code_q;
		elapsed_nxt = elapsed_q;
		case (code_q)
			ALM_CLEAR: begin
				if (above) begin
					code_nxt    = ALM_POT_ALARM;
					elapsed_nxt = '0;
				end
			end
			ALM_POT_ALARM: begin
				if (below) begin
					code_nxt = ALM_CLEAR;
				end else if (due) begin
					code_nxt = ALM_ALARM;
				end else begin
					elapsed_nxt = elapsed_q + 1'b1;
				end
			end
			ALM_ALARM: begin
				if (below) begin
					code_nxt    = ALM_POT_RECOV;
					elapsed_nxt = '0;
				end
			end
			default: begin
				if (above) begin
					code_nxt = ALM_ALARM;
				end else if (due) begin
					code_nxt = ALM_CLEAR;
				end else begin
					elapsed_nxt = elapsed_q + 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q    <= ALM_CLEAR;
			elapsed_q <= '0;
		end else if (step) begin
			code_q    <= code_nxt;
			elapsed_q <= elapsed_nxt;
		end
	end

	assign stat.code_cur = code_q;
	assign stat.code_nxt = code_nxt;

endmodule

### src/gshca_report.sv
module gshca_report (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  gshca_pkg::cfg_t cfg,
	input  logic            request,
	output logic            report_nxt
);
	import gshca_pkg::*;

	logic [REPORT_W-1:0] elapsed_q;
	logic                due;

	assign due        = (elapsed_q >= cfg.report_interval_ms);
	assign report_nxt = due | request;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
		end else if (step) begin
			elapsed_q <= due ? '0 : elapsed_q + 1'b1;
		end
	end

endmodule

### src/gas_sensor_heater_cycle_and_alert_unit.sv
// A transaction accepted is held in the input register, and its result is loaded into
// the output register when it advances, which a stalled, held result can delay.
// Throughput: one transaction per cycle unless the output stalls, via the single pass.
// Reset: arst_n clears the heater, alarm and report state and loads the configuration defaults.
module gas_sensor_heater_cycle_and_alert_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  gshca_pkg::in_item_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output gshca_pkg::out_item_t                out_data,
	input  logic                                cfg_we,
	input  logic [gshca_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [gshca_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import gshca_pkg::*;

	// The input register holds one sample tick; the state modules advance when that tick
	// moves into the output register, and the result is formed from the updated state.
	cfg_t        cfg;
	logic        in_valid_s1;
	in_item_t    in_data_s1;
	logic        out_valid_s2;
	out_item_t   out_data_s2;
	logic        accept;
	logic        advance;
	logic        phase_high_nxt;
	logic        report_nxt;
	alarm_stat_t alarm_stat;
	out_item_t   result;

	// The input register may refill in the same cycle it hands its tick on, so a stall
	// on the input side is raised only when the output register is full and held.
	assign advance  = in_valid_s1 && (!out_valid_s2 || !out_stall);
	assign in_stall = in_valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	gshca_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gshca_phase u_phase (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (advance),
		.cfg            (cfg),
		.phase_high_nxt (phase_high_nxt)
	);

	gshca_alarm u_alarm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.cfg    (cfg),
		.sample (in_data_s1.sample),
		.stat   (alarm_stat)
	);

	gshca_report u_report (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.cfg     (cfg),
		.request (in_data_s1.status_request),
		.report_nxt (report_nxt)
	);

	// The drive level is taken from the live register of the phase after this tick.
	always_comb begin
		result.heater_drive = phase_high_nxt ? cfg.high_drive_level : cfg.low_drive_level;
		result.heater_high  = phase_high_nxt;
		result.alarm_state  = alarm_stat.code_nxt;
		result.level_high   = (alarm_stat.code_nxt == ALM_ALARM) ||
		                      (alarm_stat.code_nxt == ALM_POT_RECOV);
		result.report       = report_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1  <= 1'b0;
			out_valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				in_valid_s1 <= 1'b1;
			end else if (advance) begin
				in_valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_data_s1 <= in_data;
		end
		if (advance) begin
			out_data_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	// A clear alarm can only move to a potential alarm, never straight to alarm or recovery.
	assert property (@(posedge clk) disable iff (!arst_n)
		(alarm_stat.code_cur == ALM_CLEAR) |=>
		(alarm_stat.code_cur != ALM_ALARM) && (alarm_stat.code_cur != ALM_POT_RECOV))
		else $error("alarm left the clear state other than through a potential alarm");

	// The input side never stalls while the output register is empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_s2 |-> !in_stall)
		else $error("input stalled with an empty output register");

	// A result held on the output changes only after it has been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && out_stall) |=> (out_valid_s2 && $stable(out_data_s2)))
		else $error("held result changed before it was taken");

	// Level flag agrees with the alarm code of every result leaving the block.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (out_data_s2.level_high ==
		((out_data_s2.alarm_state == ALM_ALARM) || (out_data_s2.alarm_state == ALM_POT_RECOV))))
		else $error("level flag disagrees with alarm state");

endmodule

### tb/gas_sensor_heater_cycle_and_alert_unit_tb.sv
module gas_sensor_heater_cycle_and_alert_unit_tb;

	import gshca_pkg::*;

	// Index with no register behind it; a write to it must change nothing.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

	// The run is abandoned after this many cycles, far beyond what a correct block needs.
	localparam int unsigned CYCLE_LIMIT = 400000;

	localparam int unsigned IDLE_PERCENT = 24;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_item_t               in_data;
	logic                   out_valid;
	logic                   out_stall;
	out_item_t              out_data;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// When set, neither side idles, so the block is kept busy on every cycle.
	bit calm;

	gas_sensor_heater_cycle_and_alert_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// The board keeps its own copy of the heater phase, the alarm qualifier and the report
	// timer. Every accepted input transaction advances that copy by one millisecond tick and
	// queues the tick result it should produce; every output transaction is held against
	// the oldest queued result.
	class heater_alarm_board;
		cfg_t                cfg;
		logic                phase_high;
		logic [PHASE_W-1:0]  phase_cnt;
		logic [ALARM_W-1:0]  alarm_code;
		logic [HOLD_W-1:0]   alarm_cnt;
		logic [REPORT_W-1:0] report_cnt;
		out_item_t           expected_ticks[$];
		int unsigned         errors;

		function new();
			cfg.low_phase_ms       = RST_LOW_PHASE;
			cfg.high_phase_ms      = RST_HIGH_PHASE;
			cfg.low_drive_level    = RST_LOW_LEVEL;
			cfg.high_drive_level   = RST_HIGH_LEVEL;
			cfg.alarm_threshold    = RST_THRESHOLD;
			cfg.hold_ms            = RST_HOLD;
			cfg.report_interval_ms = RST_REPORT_INTV;
			phase_high = 1'b0;
			phase_cnt  = '0;
			alarm_code = ALM_CLEAR;
			alarm_cnt  = '0;
			report_cnt = '0;
			errors     = 0;
		endfunction

		// Each register keeps only its own width of the write data.
		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LOW_PHASE:   cfg.low_phase_ms       = data[PHASE_W-1:0];
				REG_HIGH_PHASE:  cfg.high_phase_ms      = data[PHASE_W-1:0];
				REG_LOW_LEVEL:   cfg.low_drive_level    = data[LEVEL_W-1:0];
				REG_HIGH_LEVEL:  cfg.high_drive_level   = data[LEVEL_W-1:0];
				REG_THRESHOLD:   cfg.alarm_threshold    = data[THRESH_W-1:0];
				REG_HOLD:        cfg.hold_ms            = data[HOLD_W-1:0];
				REG_REPORT_INTV: cfg.report_interval_ms = data[REPORT_W-1:0];
				default: ;
			endcase
		endfunction

		// Every timer is compared with its limit before it counts, so an event falls on
		// tick limit+1, and at once if the limit has been lowered below the count.
		function void take_tick(in_item_t it);
			logic [PHASE_W-1:0] phase_lim;
			logic               above;
			logic               below;
			logic               fire;
			out_item_t          res;
			above = it.sample > cfg.alarm_threshold;
			below = it.sample < cfg.alarm_threshold;

			phase_lim = phase_high ? cfg.high_phase_ms : cfg.low_phase_ms;
			if (phase_cnt >= phase_lim) begin
				phase_high = !phase_high;
				phase_cnt  = '0;
			end else begin
				phase_cnt = phase_cnt + 1'b1;
			end

			// A sample equal to the threshold is neither above nor below it.
			case (alarm_code)
				ALM_CLEAR: begin
					if (above) begin
						alarm_code = ALM_POT_ALARM;
						alarm_cnt  = '0;
					end
				end
				ALM_POT_ALARM: begin
					if (below)
						alarm_code = ALM_CLEAR;
					else if (alarm_cnt >= cfg.hold_ms)
						alarm_code = ALM_ALARM;
					else
						alarm_cnt = alarm_cnt + 1'b1;
				end
				ALM_ALARM: begin
					if (below) begin
						alarm_code = ALM_POT_RECOV;
						alarm_cnt  = '0;
					end
				end
				default: begin
					if (above)
						alarm_code = ALM_ALARM;
					else if (alarm_cnt >= cfg.hold_ms)
						alarm_code = ALM_CLEAR;
					else
						alarm_cnt = alarm_cnt + 1'b1;
				end
			endcase

			// A status request forces a report but leaves the periodic count alone.
			fire = it.status_request;
			if (report_cnt >= cfg.report_interval_ms) begin
				report_cnt = '0;
				fire       = 1'b1;
			end else begin
				report_cnt = report_cnt + 1'b1;
			end

			res.heater_drive = phase_high ? cfg.high_drive_level : cfg.low_drive_level;
			res.heater_high  = phase_high;
			res.alarm_state  = alarm_code;
			res.level_high   = (alarm_code == ALM_ALARM) || (alarm_code == ALM_POT_RECOV);
			res.report       = fire;
			expected_ticks.push_back(res);
		endfunction

		function string describe(out_item_t r);
			return $sformatf("drive %0d high %0d alarm %0d level %0d report %0d",
				r.heater_drive, r.heater_high, r.alarm_state, r.level_high, r.report);
		endfunction

		function void match_result(out_item_t got);
			out_item_t want;
			if (expected_ticks.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("tick result with no input transaction pending: %s",
						describe(got));
				return;
			end
			want = expected_ticks.pop_front();
			if (got.heater_drive !== want.heater_drive || got.heater_high !== want.heater_high ||
					got.alarm_state !== want.alarm_state || got.level_high !== want.level_high ||
					got.report !== want.report) begin
				errors++;
				if (errors <= 10)
					$display("tick result mismatch: expected %s, got %s",
						describe(want), describe(got));
			end
		endfunction

		function int unsigned pending();
			return expected_ticks.size();
		endfunction
	endclass

	heater_alarm_board board;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The output side: a result is taken at an edge where out_valid is high and out_stall
	// is low, as sampled just after the edge and before any update it causes. The stall for
	// the next cycle is then chosen at random, unless the calm stretch is running.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.match_result(out_data);
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PERCENT);
		end
	end

	// Offers one tick to the block, after random idle cycles unless calm, and waits until
	// the transaction is accepted. The valid is left high on return, so that a following
	// tick can be offered straight away without lowering it in between.
	task automatic send_tick(input logic [SAMPLE_BITS-1:0] smp, input logic req);
		in_item_t it;
		it.sample         = smp;
		it.status_request = req;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do
			@(posedge clk);
		while (in_stall);
		board.take_tick(it);
	endtask

	// Ends a burst of ticks, waits until every queued result has come back, then lets the
	// clock run on, so the block is certainly idle before the configuration is touched.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Fills the bits above a register's width with noise, which the block must discard.
	function automatic logic [CFG_DATA_W-1:0] pad(input int unsigned val,
			input int unsigned width);
		int unsigned keep;
		int unsigned noise;
		keep  = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 1);
		noise = $urandom;
		return CFG_DATA_W'((noise & ~keep) | (val & keep));
	endfunction

	// Writes one register; the write enable stays high so that writes can follow back to
	// back, and end_config lowers it.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.set_reg(idx, data);
	endtask

	task automatic end_config();
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input int unsigned low_len, input int unsigned high_len,
			input int unsigned low_lvl, input int unsigned high_lvl, input int unsigned thr,
			input int unsigned hold, input int unsigned intv);
		write_reg(REG_LOW_PHASE, pad(low_len, PHASE_W));
		write_reg(REG_HIGH_PHASE, pad(high_len, PHASE_W));
		write_reg(REG_LOW_LEVEL, pad(low_lvl, LEVEL_W));
		write_reg(REG_HIGH_LEVEL, pad(high_lvl, LEVEL_W));
		write_reg(REG_THRESHOLD, pad(thr, THRESH_W));
		write_reg(REG_HOLD, pad(hold, HOLD_W));
		write_reg(REG_REPORT_INTV, pad(intv, REPORT_W));
		write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		end_config();
	endtask

	// Mostly short limits so that phases, alarms and reports turn over often, with the
	// zero limit and the largest limit each drawn now and then.
	function automatic int unsigned pick_limit(input int unsigned top,
			input int unsigned short_max);
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0)
			return 0;
		else if (r == 1)
			return top;
		else
			return $urandom_range(1, short_max);
	endfunction

	// Samples come in runs that sit above, below or on the threshold, so that potential
	// states survive long enough to be confirmed; some runs are plain noise over the whole
	// sample range.
	task automatic run_ticks(input int n);
		int                     left;
		int                     len;
		int unsigned            pick;
		logic [THRESH_W-1:0]    thr;
		logic [SAMPLE_BITS-1:0] smp;
		logic                   req;
		left = n;
		while (left > 0) begin
			pick = $urandom_range(9);
			len  = $urandom_range(1, 24);
			thr  = board.cfg.alarm_threshold;
			for (int i = 0; i < len && left > 0; i++) begin
				if (pick <= 3)
					smp = (thr == 12'hFFF) ? SAMPLE_BITS'($urandom) :
						SAMPLE_BITS'($urandom_range(thr + 1, 4095));
				else if (pick <= 6)
					smp = (thr == 12'h000) ? SAMPLE_BITS'($urandom) :
						SAMPLE_BITS'($urandom_range(0, thr - 1));
				else if (pick == 7)
					smp = thr;
				else
					smp = SAMPLE_BITS'($urandom);
				req = (pick >= 8) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0);
				send_tick(smp, req);
				left--;
			end
		end
	endtask

	// Gives up on a hung block.
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("gas_sensor_heater_cycle_and_alert_unit regression: fail");
		$finish;
	end

	initial begin
		board     = new();
		calm      = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_LOW_PHASE;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// A few ticks on the reset configuration, with the sample at both ends of its range.
		send_tick(12'd0, 1'b0);
		send_tick(12'd4095, 1'b1);
		send_tick(12'd800, 1'b0);
		send_tick(12'd801, 1'b0);
		drain();

		// One-tick low phase, zero hold time and a report on every tick. The walk goes
		// through every alarm state, cancels a potential alarm, and shows that a sample on
		// the threshold leaves the confirmed alarm alone.
		write_all(0, 2, 0, 255, 800, 0, 0);
		send_tick(12'd801, 1'b0);
		send_tick(12'd801, 1'b0);
		send_tick(12'd800, 1'b0);
		send_tick(12'd799, 1'b1);
		send_tick(12'd801, 1'b0);
		send_tick(12'd799, 1'b0);
		send_tick(12'd800, 1'b0);
		send_tick(12'd801, 1'b0);
		send_tick(12'd799, 1'b0);
		send_tick(12'd4095, 1'b0);
		send_tick(12'd0, 1'b1);
		send_tick(12'hAAA, 1'b0);
		send_tick(12'h555, 1'b1);
		drain();

		// The threshold at the top of its range, where no sample can lie above it.
		write_reg(REG_HOLD, pad(2, HOLD_W));
		write_reg(REG_REPORT_INTV, pad(3, REPORT_W));
		write_reg(REG_THRESHOLD, pad(4095, THRESH_W));
		end_config();
		send_tick(12'd4095, 1'b0);
		send_tick(12'd4095, 1'b0);
		send_tick(12'd0, 1'b0);
		send_tick(12'd0, 1'b0);
		drain();

		// And at the bottom, where no sample can lie below it.
		write_reg(REG_THRESHOLD, pad(0, THRESH_W));
		end_config();
		send_tick(12'd0, 1'b0);
		send_tick(12'd4095, 1'b1);
		drain();

		// Each register at its top value (high drive level at zero), then each at zero.
		write_all(262143, 262143, 255, 0, 4095, 65535, 4194303);
		run_ticks(40);
		drain();
		write_all(0, 0, 0, 0, 0, 0, 0);
		run_ticks(40);
		drain();

		// Random settings. The counters are not cleared between settings, so a limit is
		// often lowered below a running count. One of the settings runs with no idling.
		for (int p = 0; p < 8; p++) begin
			calm = (p == 3);
			write_all(pick_limit(262143, 40), pick_limit(262143, 40), $urandom_range(255),
				$urandom_range(255),
				($urandom_range(7) == 0) ? 4095 * $urandom_range(1) : $urandom_range(4095),
				pick_limit(65535, 12), pick_limit(4194303, 50));
			run_ticks(225);
			drain();
		end
		calm = 1'b0;

		if (board.errors == 0 && board.pending() == 0)
			$display("gas_sensor_heater_cycle_and_alert_unit regression: pass");
		else
			$display("gas_sensor_heater_cycle_and_alert_unit regression: fail");
		$finish;
	end

endmodule
